// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the unprojection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define SDU_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sdu: invariant violated");

// Check that a condition implies another one in the next cycle.
`define SDU_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdu: sequencing violated");

`endif

// ===== rtl/sdu_pkg.sv =====
// Types and constants of the stereo disparity unprojection unit.
package sdu_pkg;

  localparam int TAG_W   = 12;
  localparam int PIX_W   = 16;
  localparam int DISP_W  = 16;
  localparam int DIVR_W  = 15;  // positive disparity magnitude
  localparam int NUM_W   = 36;  // focal_baseline * 16
  localparam int COORD_W = 24;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;

  localparam logic [44:0] CAM_LIM = 45'h0FF_FFFF_FFFF;  // 2^40 - 1

  typedef enum logic [2:0] {
    REG_FOCAL_BASELINE = 3'd0,
    REG_PRINCIPAL      = 3'd1,
    REG_INV_FOCAL      = 3'd2,
    REG_DEPTH_LIMIT    = 3'd3,
    REG_ROT_ROW0       = 3'd4,
    REG_ROT_ROW1       = 3'd5,
    REG_ROT_ROW2       = 3'd6,
    REG_CENTRE         = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]      focal_baseline;
    logic [31:0]      principal;
    logic [47:0]      inv_focal;
    logic [31:0]      depth_limit;
    logic [2:0][59:0] rot_rows;
    logic [62:0]      centre;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PIX_W-1:0]  u;
    logic [PIX_W-1:0]  v;
    logic [DIVR_W-1:0] disp;
  } item_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic [2:0][COORD_W-1:0]   world;  // index 0 = x, 1 = y, 2 = z
  } res_t;

endpackage

// ===== rtl/stereo_disparity_unprojection_unit.sv =====
// Top level of the stereo disparity unprojection unit.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | push / full        | in_point_tag, in_pixel_u, in_pixel_v,
//          |                    | in_disparity_raw
//  result  | empty / pop        | out_point_tag_out, out_world_x/y/z
//  config  | psel/penable/pready| paddr (register i at 8*i), pwdata, prdata
//
//  One request is accepted per cycle while full is low; a kept point passes
//  through the front queue, the bit-per-stage depth divider and the
//  projection and rotation stages before it reaches the result ports.
//  The divider pipeline sets the latency; the rate stays one per cycle
//  unless the result queue stalls. Requests with non-positive disparity,
//  zero depth or depth at or beyond the limit give no result and leave no
//  gap in the stream. A full result queue stalls the back end; the front
//  queue then fills and raises full. Reset (synchronous, rst_n low) empties
//  both queues and clears the calibration registers and valid flags to zero.
module stereo_disparity_unprojection_unit #(
  parameter int QUEUE_DEPTH = 4   // entries in each queue, 2 or more
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input requests
  input  logic                                push,
  output logic                                full,
  input  logic [sdu_pkg::TAG_W-1:0]           in_point_tag,
  input  logic [sdu_pkg::PIX_W-1:0]           in_pixel_u,
  input  logic [sdu_pkg::PIX_W-1:0]           in_pixel_v,
  input  logic signed [sdu_pkg::DISP_W-1:0]   in_disparity_raw,
  // results
  output logic                                empty,
  input  logic                                pop,
  output logic [sdu_pkg::TAG_W-1:0]           out_point_tag_out,
  output logic signed [sdu_pkg::COORD_W-1:0]  out_world_x,
  output logic signed [sdu_pkg::COORD_W-1:0]  out_world_y,
  output logic signed [sdu_pkg::COORD_W-1:0]  out_world_z,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sdu_pkg::ADDR_W-1:0]          paddr,
  input  logic [sdu_pkg::DATA_W-1:0]          pwdata,
  output logic [sdu_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  sdu_pkg::cfg_t  cfg;
  sdu_pkg::item_t fq_item;
  sdu_pkg::item_t div_item;
  sdu_pkg::res_t  res;
  logic           fq_valid;
  logic           adv;
  logic           div_valid;
  logic [sdu_pkg::NUM_W-1:0] div_quot;

  // Calibration registers; the user must write them only while the unit is idle (not enforced here).
  sdu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: accept, drop non-positive disparities, queue the rest.
  sdu_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_point_tag     (in_point_tag),
    .in_pixel_u       (in_pixel_u),
    .in_pixel_v       (in_pixel_v),
    .in_disparity_raw (in_disparity_raw),
    .fq_valid         (fq_valid),
    .fq_item          (fq_item),
    .fq_pop           (adv)
  );

  // Depth divider; advances in lock step with the back end.
  sdu_div u_div (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (fq_valid),
    .in_item        (fq_item),
    .focal_baseline (cfg.focal_baseline),
    .out_valid      (div_valid),
    .out_item       (div_item),
    .out_quot       (div_quot)
  );

  // Back: depth window, back-projection, rotation, offset, result queue.
  sdu_back #(.DEPTH(QUEUE_DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .d_valid (div_valid),
    .d_item  (div_item),
    .d_quot  (div_quot),
    .adv     (adv),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_point_tag_out = res.tag;
  assign out_world_x       = res.world[0];
  assign out_world_y       = res.world[1];
  assign out_world_z       = res.world[2];

endmodule

// ===== rtl/sdu_cfg.sv =====
// APB register file holding the calibration of the unprojection unit.
module sdu_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdu_pkg::ADDR_W-1:0]   paddr,
  input  logic [sdu_pkg::DATA_W-1:0]   pwdata,
  output logic [sdu_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output sdu_pkg::cfg_t                cfg
);

  sdu_pkg::cfg_t    cfg_r;
  sdu_pkg::reg_idx_t idx;
  logic             wr;

  assign idx    = sdu_pkg::reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (idx)
        sdu_pkg::REG_FOCAL_BASELINE: cfg_r.focal_baseline <= pwdata[31:0];
        sdu_pkg::REG_PRINCIPAL:      cfg_r.principal      <= pwdata[31:0];
        sdu_pkg::REG_INV_FOCAL:      cfg_r.inv_focal      <= pwdata[47:0];
        sdu_pkg::REG_DEPTH_LIMIT:    cfg_r.depth_limit    <= pwdata[31:0];
        sdu_pkg::REG_ROT_ROW0:       cfg_r.rot_rows[0]    <= pwdata[59:0];
        sdu_pkg::REG_ROT_ROW1:       cfg_r.rot_rows[1]    <= pwdata[59:0];
        sdu_pkg::REG_ROT_ROW2:       cfg_r.rot_rows[2]    <= pwdata[59:0];
        sdu_pkg::REG_CENTRE:         cfg_r.centre         <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sdu_pkg::REG_FOCAL_BASELINE: prdata = {32'd0, cfg_r.focal_baseline};
      sdu_pkg::REG_PRINCIPAL:      prdata = {32'd0, cfg_r.principal};
      sdu_pkg::REG_INV_FOCAL:      prdata = {16'd0, cfg_r.inv_focal};
      sdu_pkg::REG_DEPTH_LIMIT:    prdata = {32'd0, cfg_r.depth_limit};
      sdu_pkg::REG_ROT_ROW0:       prdata = {4'd0, cfg_r.rot_rows[0]};
      sdu_pkg::REG_ROT_ROW1:       prdata = {4'd0, cfg_r.rot_rows[1]};
      sdu_pkg::REG_ROT_ROW2:       prdata = {4'd0, cfg_r.rot_rows[2]};
      sdu_pkg::REG_CENTRE:         prdata = {1'b0, cfg_r.centre};
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sdu_front.sv =====
// Front end: accept requests, drop non-positive disparities, queue the rest.
module sdu_front #(
  parameter int DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [sdu_pkg::TAG_W-1:0]          in_point_tag,
  input  logic [sdu_pkg::PIX_W-1:0]          in_pixel_u,
  input  logic [sdu_pkg::PIX_W-1:0]          in_pixel_v,
  input  logic signed [sdu_pkg::DISP_W-1:0]  in_disparity_raw,
  output logic                               fq_valid,
  output sdu_pkg::item_t                     fq_item,
  input  logic                               fq_pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sdu_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           accept, keep, pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign accept   = push && !full;
  // positive disparity only: sign clear and magnitude nonzero
  assign keep     = accept && !in_disparity_raw[sdu_pkg::DISP_W-1] &&
                    (in_disparity_raw != '0);
  assign fq_valid = (cnt_r != '0);
  assign pop      = fq_pop && fq_valid;
  assign fq_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (keep) begin
      mem_r[wr_ptr_r] <= '{tag:  in_point_tag,
                           u:    in_pixel_u,
                           v:    in_pixel_v,
                           disp: in_disparity_raw[sdu_pkg::DIVR_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (keep) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({keep, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/sdu_div.sv =====
// Pipelined restoring divider: depth = focal_baseline * 16 / disparity.
module sdu_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  sdu_pkg::item_t                  in_item,
  input  logic [31:0]                     focal_baseline,
  output logic                            out_valid,
  output sdu_pkg::item_t                  out_item,
  output logic [sdu_pkg::NUM_W-1:0]       out_quot
);

  localparam int N  = sdu_pkg::NUM_W;
  localparam int RW = sdu_pkg::DIVR_W;

  logic           v_r    [N];
  logic [RW-1:0]  rem_r  [N];
  logic [N-1:0]   nq_r   [N];   // dividend bits shift out, quotient bits shift in
  sdu_pkg::item_t meta_r [N];

  logic [RW-1:0]  rem_nxt  [N];
  logic [N-1:0]   nq_nxt   [N];
  sdu_pkg::item_t meta_nxt [N];

  always_comb begin
    logic [RW-1:0]  p_rem;
    logic [N-1:0]   p_nq;
    sdu_pkg::item_t p_meta;
    logic [RW:0]    cand;
    logic [RW:0]    diff;
    logic           ge;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        p_rem  = '0;
        p_nq   = {focal_baseline, 4'd0};
        p_meta = in_item;
      end else begin
        p_rem  = rem_r[s-1];
        p_nq   = nq_r[s-1];
        p_meta = meta_r[s-1];
      end
      cand        = {p_rem, p_nq[N-1]};
      ge          = (cand >= {1'b0, p_meta.disp});
      diff        = cand - {1'b0, p_meta.disp};
      rem_nxt[s]  = ge ? diff[RW-1:0] : cand[RW-1:0];
      nq_nxt[s]   = {p_nq[N-2:0], ge};
      meta_nxt[s] = p_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < N; s++) begin
        rem_r[s]  <= rem_nxt[s];
        nq_r[s]   <= nq_nxt[s];
        meta_r[s] <= meta_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < N; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < N; s++) v_r[s] <= v_r[s-1];
    end
  end

  assign out_valid = v_r[N-1];
  assign out_item  = meta_r[N-1];
  assign out_quot  = nq_r[N-1];

endmodule

// ===== rtl/sdu_back.sv =====
// Back end: depth check, back-projection, rotation, offset and result queue.
`include "assert_macros.svh"

module sdu_back #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sdu_pkg::cfg_t              cfg,
  input  logic                       d_valid,
  input  sdu_pkg::item_t             d_item,
  input  logic [sdu_pkg::NUM_W-1:0]  d_quot,
  output logic                       adv,
  output logic                       empty,
  input  logic                       pop,
  output sdu_pkg::res_t              res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // B1: depth window, pixel offsets
  logic                     vb1_r;
  logic [31:0]              z1_r;
  logic signed [16:0]       dp1_r [2];
  logic [11:0]              tag1_r;
  // B2: offset times depth
  logic                     vb2_r;
  logic [31:0]              z2_r;
  logic signed [48:0]       t2_r [2];
  logic [11:0]              tag2_r;
  // B3: magnitude and sign
  logic                     vb3_r;
  logic [31:0]              z3_r;
  logic [47:0]              m3_r [2];
  logic                     n3_r [2];
  logic [11:0]              tag3_r;
  // B4: partial products with the inverse focal length
  logic                     vb4_r;
  logic [31:0]              z4_r;
  logic [59:0]              ph4_r [2];
  logic [59:0]              pl4_r [2];
  logic                     n4_r [2];
  logic [11:0]              tag4_r;
  // B5: scaled magnitude
  logic                     vb5_r;
  logic [31:0]              z5_r;
  logic [44:0]              r5_r [2];
  logic                     n5_r [2];
  logic [11:0]              tag5_r;
  // B6: clamped signed camera coordinates
  logic                     vb6_r;
  logic [31:0]              z6_r;
  logic signed [40:0]       c6_r [2];
  logic [11:0]              tag6_r;
  // B7: rotation products
  logic                     vb7_r;
  logic signed [60:0]       p7_r [3][3];
  logic [11:0]              tag7_r;
  // B8: row sums
  logic                     vb8_r;
  logic signed [62:0]       s8_r [3];
  logic [11:0]              tag8_r;
  // B9: truncated scale
  logic                     vb9_r;
  logic signed [44:0]       t9_r [3];
  logic [11:0]              tag9_r;
  // B10: offset and saturated result
  logic                     vb10_r;
  sdu_pkg::res_t            res10_r;

  // combinational next values
  logic                     keep1;
  logic signed [16:0]       dp_nxt [2];
  logic signed [48:0]       t_nxt [2];
  logic [47:0]              m_nxt [2];
  logic [59:0]              ph_nxt [2];
  logic [59:0]              pl_nxt [2];
  logic [44:0]              r_nxt [2];
  logic signed [40:0]       c_nxt [2];
  logic signed [60:0]       p_nxt [3][3];
  logic signed [62:0]       s_nxt [3];
  logic signed [44:0]       tr_nxt [3];
  logic [sdu_pkg::COORD_W-1:0] w_nxt [3];

  logic          oq_full, oq_push, oq_pop;
  sdu_pkg::res_t oq_mem_r [DEPTH];
  logic [AW-1:0] oq_wr_r, oq_rd_r;
  logic [CW-1:0] oq_cnt_r;

  assign oq_full = (oq_cnt_r == CW'(DEPTH));
  // hold the whole pipe only when a finished result finds the queue full
  assign adv     = !(vb10_r && oq_full);
  assign oq_push = vb10_r && !oq_full;
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_cnt_r == '0);
  assign res     = oq_mem_r[oq_rd_r];

  assign keep1 = d_valid && (d_quot != '0) &&
                 (d_quot < {4'd0, cfg.depth_limit});

  always_comb begin
    logic [23:0]        inv;
    logic signed [49:0] prod;
    logic signed [48:0] neg;
    logic [60:0]        acc;
    logic [39:0]        mag;
    logic signed [19:0] a;
    logic signed [40:0] opnd;
    logic signed [62:0] bias;
    logic signed [62:0] shf;
    logic signed [45:0] w;
    for (int k = 0; k < 2; k++) begin
      dp_nxt[k] = (k == 0)
        ? $signed({1'b0, d_item.u}) - $signed({1'b0, cfg.principal[15:0]})
        : $signed({1'b0, d_item.v}) - $signed({1'b0, cfg.principal[31:16]});
      prod     = dp1_r[k] * $signed({1'b0, z1_r});
      t_nxt[k] = prod[48:0];
      neg      = -t2_r[k];
      m_nxt[k] = t2_r[k][48] ? neg[47:0] : t2_r[k][47:0];
      inv       = (k == 0) ? cfg.inv_focal[23:0] : cfg.inv_focal[47:24];
      ph_nxt[k] = m3_r[k] * inv[23:12];
      pl_nxt[k] = m3_r[k] * inv[11:0];
      acc      = {1'b0, ph4_r[k]} + {13'd0, pl4_r[k][59:12]};
      r_nxt[k] = acc[60:16];
      mag      = (r5_r[k] > sdu_pkg::CAM_LIM) ? sdu_pkg::CAM_LIM[39:0] : r5_r[k][39:0];
      c_nxt[k] = n5_r[k] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a = $signed(cfg.rot_rows[i][20*j +: 20]);
        opnd = (j == 2) ? 41'($signed({1'b0, z6_r})) : c6_r[j];
        p_nxt[i][j] = a * opnd;
      end
      s_nxt[i] = 63'(p7_r[i][0]) + 63'(p7_r[i][1]) + 63'(p7_r[i][2]);
      // truncate toward zero: bias negative sums before the shift
      bias = s8_r[i] + 63'sd262143;
      shf  = s8_r[i][62] ? (bias >>> 18) : (s8_r[i] >>> 18);
      tr_nxt[i] = shf[44:0];
      w = 46'(t9_r[i]) + 46'($signed({cfg.centre[21*i +: 21], 1'b0}));
      if (w > 46'sd8388607) begin
        w_nxt[i] = 24'h7F_FFFF;
      end else if (w < -46'sd8388608) begin
        w_nxt[i] = 24'h80_0000;
      end else begin
        w_nxt[i] = w[23:0];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      z1_r   <= d_quot[31:0];
      tag1_r <= d_item.tag;
      z2_r   <= z1_r;
      tag2_r <= tag1_r;
      z3_r   <= z2_r;
      tag3_r <= tag2_r;
      z4_r   <= z3_r;
      tag4_r <= tag3_r;
      z5_r   <= z4_r;
      tag5_r <= tag4_r;
      z6_r   <= z5_r;
      tag6_r <= tag5_r;
      tag7_r <= tag6_r;
      tag8_r <= tag7_r;
      tag9_r <= tag8_r;
      res10_r.tag <= tag9_r;
      for (int k = 0; k < 2; k++) begin
        dp1_r[k] <= dp_nxt[k];
        t2_r[k]  <= t_nxt[k];
        m3_r[k]  <= m_nxt[k];
        n3_r[k]  <= t2_r[k][48];
        ph4_r[k] <= ph_nxt[k];
        pl4_r[k] <= pl_nxt[k];
        n4_r[k]  <= n3_r[k];
        r5_r[k]  <= r_nxt[k];
        n5_r[k]  <= n4_r[k];
        c6_r[k]  <= c_nxt[k];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) p7_r[i][j] <= p_nxt[i][j];
        s8_r[i]          <= s_nxt[i];
        t9_r[i]          <= tr_nxt[i];
        res10_r.world[i] <= w_nxt[i];
      end
    end
  end

  // valid chain; rejected depths drop out at the first stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb1_r  <= 1'b0;
      vb2_r  <= 1'b0;
      vb3_r  <= 1'b0;
      vb4_r  <= 1'b0;
      vb5_r  <= 1'b0;
      vb6_r  <= 1'b0;
      vb7_r  <= 1'b0;
      vb8_r  <= 1'b0;
      vb9_r  <= 1'b0;
      vb10_r <= 1'b0;
    end else if (adv) begin
      vb1_r  <= keep1;
      vb2_r  <= vb1_r;
      vb3_r  <= vb2_r;
      vb4_r  <= vb3_r;
      vb5_r  <= vb4_r;
      vb6_r  <= vb5_r;
      vb7_r  <= vb6_r;
      vb8_r  <= vb7_r;
      vb9_r  <= vb8_r;
      vb10_r <= vb9_r;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= res10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= (oq_wr_r == AW'(DEPTH - 1)) ? '0 : oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= (oq_rd_r == AW'(DEPTH - 1)) ? '0 : oq_rd_r + 1'b1;
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + 1'b1;
        2'b01:   oq_cnt_r <= oq_cnt_r - 1'b1;
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

  `SDU_CHECK(a_oq_bound, oq_cnt_r <= CW'(DEPTH))
  `SDU_CHECK(a_depth_window, !vb1_r || (z1_r != '0 && z1_r < cfg.depth_limit))
  `SDU_CHECK_NEXT(a_stall_holds, vb10_r && oq_full && !oq_pop, vb10_r && !adv)

endmodule
